// ===== design/kwms_pkg.sv =====
// Shared types, constants and helpers for the k-way merge selector.
package kwms_pkg;

    localparam int MAX_RUNS     = 8;
    localparam int BUFFER_DEPTH = 64;

    localparam int RUN_W     = $clog2(MAX_RUNS);           // run index width
    localparam int ACT_W     = RUN_W + 1;                  // holds 1..MAX_RUNS
    localparam int NODE_N    = 1 << RUN_W;                 // leaves of the min tree
    localparam int PTR_W     = $clog2(BUFFER_DEPTH);
    localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W    = RUN_W + PTR_W;
    localparam int MEM_DEPTH = NODE_N << PTR_W;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 3;
    localparam int REQ_W     = 2;
    localparam int CFG_W     = 4;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FINISH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd0;
    localparam logic [STAT_W-1:0] ST_REJECT = 3'd1;
    localparam logic [STAT_W-1:0] ST_POPPED = 3'd2;
    localparam logic [STAT_W-1:0] ST_STALL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DONE   = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [RUN_W-1:0]         run_index;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] merged_value;
        logic [RUN_W-1:0]         source_run;
        logic                     final_item;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic cfg_write;
        logic eval;
        logic commit;
        logic refill;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_pop;
        logic refill_need;
    } dp_sts_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

// ===== design/k_way_merge_selector_unit.sv =====
// Top level of the k-way merge selector: controller plus datapath.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_data (in_item_t: request, run, value)
//  m_      | out       | m_valid / m_ready    | m_data (out_item_t: status, value, run, last)
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_data (active run count, 4 bits)
//
// One transaction is worked at a time. Push and finish go from accept to commit; a pop
// first evaluates the 8-input min tree into registers, then commits, plus a refill step
// when the popped run still holds data and its next head is read from the buffer RAM.
// Reset (aresetn low, synchronous) and any cfg write clear all pointers, counts
// and finished flags at once; no clearing pass is needed.
// A result waiting in the output register holds the commit step until taken.
module k_way_merge_selector_unit import kwms_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: accepts, steps the datapath, drives the output valid
    kwms_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // buffers, per-run heads, min tree, result register
    kwms_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_data   (s_data),
        .cfg_data (cfg_data),
        .m_data   (m_data)
    );

endmodule

// ===== design/kwms_datapath.sv =====
// Datapath: run buffers, head registers, pointers, min tree and result register.
module kwms_datapath import kwms_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts,
    input  in_item_t         s_data,
    input  logic [CFG_W-1:0] cfg_data,
    output out_item_t        m_data
);

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] mem_q_reg;

    logic [PTR_W-1:0]  rp_reg   [MAX_RUNS];
    logic [PTR_W-1:0]  wp_reg   [MAX_RUNS];
    logic [CNT_W-1:0]  cnt_reg  [MAX_RUNS];
    logic [MAX_RUNS-1:0] fin_reg;
    logic signed [DATA_W-1:0] head_reg [MAX_RUNS];
    logic [ACT_W-1:0]  active_reg;

    in_item_t          item_reg;
    out_item_t         result_reg;

    logic [RUN_W-1:0]         best_idx_reg;
    logic signed [DATA_W-1:0] best_val_reg;
    logic                     any_reg;
    logic                     stall_reg;

    // per-run flags
    logic [MAX_RUNS-1:0] active_mask;
    logic [MAX_RUNS-1:0] live_vec;
    logic [MAX_RUNS-1:0] stall_vec;

    always_comb begin
        for (int r = 0; r < MAX_RUNS; r++) begin
            active_mask[r] = ACT_W'(r) < active_reg;
            live_vec[r]    = !(fin_reg[r] && (cnt_reg[r] == '0));
            stall_vec[r]   = active_mask[r] && !fin_reg[r] && (cnt_reg[r] == '0);
        end
    end

    // min tree over the heads, lowest index wins ties
    logic                     node_ok  [RUN_W+1][NODE_N];
    logic signed [DATA_W-1:0] node_val [RUN_W+1][NODE_N];
    logic [RUN_W-1:0]         node_idx [RUN_W+1][NODE_N];

    always_comb begin
        for (int lv = 0; lv <= RUN_W; lv++) begin
            for (int i = 0; i < NODE_N; i++) begin
                node_ok[lv][i]  = 1'b0;
                node_val[lv][i] = '0;
                node_idx[lv][i] = '0;
            end
        end
        for (int i = 0; i < NODE_N; i++) begin
            if (i < MAX_RUNS) begin
                node_ok[0][i]  = active_mask[i] && (cnt_reg[i] != '0);
                node_val[0][i] = head_reg[i];
                node_idx[0][i] = RUN_W'(i);
            end
        end
        for (int lv = 0; lv < RUN_W; lv++) begin
            for (int i = 0; i < (NODE_N >> (lv + 1)); i++) begin
                if (node_ok[lv][2*i+1] && (!node_ok[lv][2*i] ||
                    (node_val[lv][2*i+1] < node_val[lv][2*i]))) begin
                    node_ok[lv+1][i]  = 1'b1;
                    node_val[lv+1][i] = node_val[lv][2*i+1];
                    node_idx[lv+1][i] = node_idx[lv][2*i+1];
                end else begin
                    node_ok[lv+1][i]  = node_ok[lv][2*i];
                    node_val[lv+1][i] = node_val[lv][2*i];
                    node_idx[lv+1][i] = node_idx[lv][2*i];
                end
            end
        end
    end

    // commit decode
    logic [RUN_W-1:0]  run;
    logic              in_range;
    logic              push_ok;
    logic              fin_ok;
    logic              pop_ok;
    logic [MAX_RUNS-1:0] live_after;
    out_item_t         res_next;

    always_comb begin
        run        = item_reg.run_index;
        in_range   = {1'b0, run} < active_reg;
        push_ok    = 1'b0;
        fin_ok     = 1'b0;
        pop_ok     = 1'b0;
        live_after = live_vec & active_mask;
        live_after[best_idx_reg] = !(fin_reg[best_idx_reg] &&
                                     (cnt_reg[best_idx_reg] == CNT_W'(1)));
        res_next        = '0;
        res_next.status = ST_REJECT;
        case (item_reg.req_type)
            REQ_PUSH: begin
                if (in_range && !fin_reg[run] &&
                    (cnt_reg[run] < CNT_W'(BUFFER_DEPTH))) begin
                    push_ok         = 1'b1;
                    res_next.status = ST_ACCEPT;
                end
            end
            REQ_FINISH: begin
                if (in_range) begin
                    fin_ok          = 1'b1;
                    res_next.status = ST_ACCEPT;
                end
            end
            REQ_POP: begin
                if (stall_reg) begin
                    res_next.status = ST_STALL;
                end else if (!any_reg) begin
                    res_next.status = ST_DONE;
                end else begin
                    pop_ok                = 1'b1;
                    res_next.status       = ST_POPPED;
                    res_next.merged_value = best_val_reg;
                    res_next.source_run   = best_idx_reg;
                    res_next.final_item   = ~|live_after;
                end
            end
            default: begin
                res_next.status = ST_REJECT;
            end
        endcase
    end

    // pop decode taken from the offered payload, used on the accepting edge
    assign sts.is_pop      = (s_data.req_type == REQ_POP);
    assign sts.refill_need = pop_ok && (cnt_reg[best_idx_reg] > CNT_W'(1));

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACT_W'(MAX_RUNS);
            fin_reg    <= '0;
            for (int r = 0; r < MAX_RUNS; r++) begin
                rp_reg[r]  <= '0;
                wp_reg[r]  <= '0;
                cnt_reg[r] <= '0;
            end
        end else if (cmd.cfg_write) begin
            if (cfg_data == '0) begin
                active_reg <= ACT_W'(1);
            end else if (cfg_data > CFG_W'(MAX_RUNS)) begin
                active_reg <= ACT_W'(MAX_RUNS);
            end else begin
                active_reg <= ACT_W'(cfg_data);
            end
            fin_reg <= '0;
            for (int r = 0; r < MAX_RUNS; r++) begin
                rp_reg[r]  <= '0;
                wp_reg[r]  <= '0;
                cnt_reg[r] <= '0;
            end
        end else if (cmd.commit) begin
            if (push_ok) begin
                wp_reg[run]  <= ptr_inc(wp_reg[run]);
                cnt_reg[run] <= cnt_reg[run] + CNT_W'(1);
            end
            if (fin_ok) begin
                fin_reg[run] <= 1'b1;
            end
            if (pop_ok) begin
                rp_reg[best_idx_reg]  <= ptr_inc(rp_reg[best_idx_reg]);
                cnt_reg[best_idx_reg] <= cnt_reg[best_idx_reg] - CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.eval) begin
            best_idx_reg <= node_idx[RUN_W][0];
            best_val_reg <= node_val[RUN_W][0];
            any_reg      <= node_ok[RUN_W][0];
            stall_reg    <= |stall_vec;
        end
        if (cmd.commit) begin
            result_reg <= res_next;
            // push into an empty run sets its head directly
            if (push_ok && (cnt_reg[run] == '0)) begin
                head_reg[run] <= item_reg.value;
            end
        end
        if (cmd.refill) begin
            head_reg[best_idx_reg] <= mem_q_reg;
        end
    end

    // run buffer memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.commit && push_ok) begin
            mem[{run, wp_reg[run]}] <= item_reg.value;
        end
        if (cmd.commit) begin
            mem_q_reg <= mem[{best_idx_reg, ptr_inc(rp_reg[best_idx_reg])}];
        end
    end

    assign m_data = result_reg;

endmodule

// ===== design/kwms_ctrl.sv =====
// Controller: sequences one transaction at a time and owns the output valid.
module kwms_ctrl import kwms_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;
    localparam logic [1:0] S_REFILL = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       s_fire, commit_fire;

    assign s_ready     = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready   = (state_reg == S_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign commit_fire = (state_reg == S_COMMIT) && (!out_valid_reg || m_ready);
    assign m_valid     = out_valid_reg;

    always_comb begin
        cmd.load_item = s_fire;
        cmd.cfg_write = cfg_valid && cfg_ready;
        cmd.eval      = (state_reg == S_EVAL);
        cmd.commit    = commit_fire;
        cmd.refill    = (state_reg == S_REFILL);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                // non-pop items skip the min-tree evaluation cycle
                if (s_fire) begin
                    state_next = sts.is_pop ? S_EVAL : S_COMMIT;
                end
            end
            S_EVAL: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit_fire) begin
                    state_next = sts.refill_need ? S_REFILL : S_IDLE;
                end
            end
            S_REFILL: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (commit_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/kwms_checker.sv =====
// Port-level checker for the k-way merge selector, bound to the top level.
module kwms_checker import kwms_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data,
    input logic      cfg_valid,
    input logic      cfg_ready
);

    // a held result does not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // only a popped value carries payload
    a_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_POPPED) |->
            (m_data.merged_value == '0) && (m_data.source_run == '0) &&
            !m_data.final_item)
        else $error("payload on non-pop result");

    // one transaction in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("back-to-back accept");

    // a cfg write never lands together with an input accept
    a_cfg_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |-> !(s_valid && s_ready))
        else $error("cfg write during input accept");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_ACCEPT) || (m_data.status == ST_REJECT) ||
                    (m_data.status == ST_POPPED) || (m_data.status == ST_STALL) ||
                    (m_data.status == ST_DONE))
        else $error("bad status code");

endmodule

bind k_way_merge_selector_unit kwms_checker u_kwms_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== dv/tb_k_way_merge_selector_unit.sv =====
// Self-checking testbench for k_way_merge_selector_unit: directed and random merge traffic.
`timescale 1ns / 100ps

module tb_k_way_merge_selector_unit;
    import kwms_pkg::*;

    // The package defines no name for the unused request encoding.
    localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // Idle time after the last result is taken, so any work still in flight can finish.
    localparam int QUIET_CYCLES = 4;
    localparam int SHOW_LIMIT   = 10;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    k_way_merge_selector_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror of the merge engine: per-run FIFOs, pointers, fill levels,
    // finished flags and the active run count.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] run_mem [MAX_RUNS][BUFFER_DEPTH];
    logic [PTR_W-1:0]         rd_ptr  [MAX_RUNS];
    logic [PTR_W-1:0]         wr_ptr  [MAX_RUNS];
    logic [CNT_W-1:0]         run_fill[MAX_RUNS];
    bit                       run_closed[MAX_RUNS];
    logic [ACT_W-1:0]         run_count;

    // Outcomes predicted at input acceptance, oldest first.
    out_item_t pending_outcomes[$];
    out_item_t latest_outcome;

    // Idling controls for the two sides of the block.
    bit src_gaps;
    bit sink_stalls;

    int unsigned err_count;
    int unsigned n_requests, n_pops, n_closing, n_stalls, n_rejects, n_done;
    int unsigned n_cfg_writes, n_sessions;

    function automatic void clear_runs();
        for (int r = 0; r < MAX_RUNS; r++) begin
            rd_ptr[r]     = '0;
            wr_ptr[r]     = '0;
            run_fill[r]   = '0;
            run_closed[r] = 1'b0;
        end
    endfunction

    // Works out the block's answer to one request and advances the mirror.
    function automatic out_item_t merge_outcome(in_item_t req);
        out_item_t                res;
        logic [RUN_W-1:0]         sel;
        logic [RUN_W-1:0]         best_run;
        logic signed [DATA_W-1:0] best_val;
        logic signed [DATA_W-1:0] head;
        bit                       found;
        bit                       starved;
        res        = '0;
        res.status = ST_REJECT;
        sel        = req.run_index;
        case (req.req_type)
            REQ_PUSH: begin
                if (sel < run_count && !run_closed[sel] && run_fill[sel] < BUFFER_DEPTH) begin
                    run_mem[sel][wr_ptr[sel]] = req.value;
                    wr_ptr[sel]   = wr_ptr[sel] + 1'b1;
                    run_fill[sel] = run_fill[sel] + 1'b1;
                    res.status    = ST_ACCEPT;
                end
            end
            REQ_FINISH: begin
                if (sel < run_count) begin
                    run_closed[sel] = 1'b1;
                    res.status      = ST_ACCEPT;
                end
            end
            REQ_POP: begin
                found    = 1'b0;
                starved  = 1'b0;
                best_run = '0;
                best_val = '0;
                for (int r = 0; r < MAX_RUNS; r++) begin
                    if (r < run_count && !(run_closed[r] && run_fill[r] == 0)) begin
                        if (run_fill[r] == 0) begin
                            // open run with nothing buffered: it may still get a smaller value
                            starved = 1'b1;
                        end else begin
                            head = run_mem[r][rd_ptr[r]];
                            if (!found || head < best_val) begin
                                found    = 1'b1;
                                best_run = RUN_W'(r);
                                best_val = head;
                            end
                        end
                    end
                end
                if (starved) begin
                    res.status = ST_STALL;
                end else if (!found) begin
                    res.status = ST_DONE;
                end else begin
                    rd_ptr[best_run]   = rd_ptr[best_run] + 1'b1;
                    run_fill[best_run] = run_fill[best_run] - 1'b1;
                    res.status         = ST_POPPED;
                    res.merged_value   = best_val;
                    res.source_run     = best_run;
                    res.final_item     = 1'b1;
                    for (int r = 0; r < MAX_RUNS; r++) begin
                        if (r < run_count && !(run_closed[r] && run_fill[r] == 0)) begin
                            res.final_item = 1'b0;
                        end
                    end
                end
            end
            default: res.status = ST_REJECT;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    // Sends one request transaction. Valid stays high across back-to-back
    // transactions; it only drops when a gap is drawn or when wait_merge_quiet holds the sender off.
    task automatic issue_request(input logic [REQ_W-1:0] kind, input logic [RUN_W-1:0] run,
                                 input logic signed [DATA_W-1:0] value);
        in_item_t    req;
        int unsigned gap;
        req.req_type  = kind;
        req.run_index = run;
        req.value     = value;
        gap = src_gaps ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        latest_outcome = merge_outcome(req);
        pending_outcomes.push_back(latest_outcome);
        n_requests++;
        case (latest_outcome.status)
            ST_POPPED: begin
                n_pops++;
                if (latest_outcome.final_item) n_closing++;
            end
            ST_STALL:  n_stalls++;
            ST_REJECT: n_rejects++;
            ST_DONE:   n_done++;
            default: ;
        endcase
    endtask

    // Holds the sender off until every outstanding result has been taken.
    task automatic wait_merge_quiet();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Writes the active run count; only ever done with the block idle.
    task automatic write_run_count(input logic [CFG_W-1:0] code);
        wait_merge_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (code == 0)             run_count = ACT_W'(1);
        else if (code > MAX_RUNS)  run_count = ACT_W'(MAX_RUNS);
        else                       run_count = ACT_W'(code);
        clear_runs();
        n_cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order comparison.
    // ------------------------------------------------------------------
    task automatic flag_result(input string why, input out_item_t want, input out_item_t got);
        err_count++;
        if (err_count <= SHOW_LIMIT) begin
            $display({"[%0t] %s: expected status=%0d value=%0d run=%0d last=%0b,",
                      " got status=%0d value=%0d run=%0d last=%0b"},
                     $realtime, why, want.status, want.merged_value, want.source_run,
                     want.final_item, got.status, got.merged_value, got.source_run,
                     got.final_item);
        end
    endtask

    initial begin : result_checker
        int unsigned hold;
        out_item_t   want;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            hold = sink_stalls ? $urandom_range(0, 5) : 0;
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            if (pending_outcomes.size() == 0) begin
                flag_result("result with nothing pending", '0, m_data);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_data.status !== want.status || m_data.merged_value !== want.merged_value ||
                    m_data.source_run !== want.source_run ||
                    m_data.final_item !== want.final_item) begin
                    flag_result("result mismatch", want, m_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value of the run count (8), value extremes, ties, stalls,
    // finish handling, undefined request code and the all-done answer.
    task automatic test_reset_merge_rules();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        issue_request(REQ_POP,    3'd0, '0);          // every run open and empty: stall
        issue_request(REQ_PUSH,   3'd0, VAL_MAX);
        issue_request(REQ_PUSH,   3'd7, VAL_MIN);
        issue_request(REQ_PUSH,   3'd3, -32'sd1);
        issue_request(REQ_PUSH,   3'd5, VAL_MAX);     // ties with run 0
        issue_request(REQ_FINISH, 3'd1, '0);
        issue_request(REQ_FINISH, 3'd2, '0);
        issue_request(REQ_FINISH, 3'd4, '0);
        issue_request(REQ_FINISH, 3'd6, 32'sh5555_aaaa);
        issue_request(REQ_POP,    3'd0, '0);          // most negative value from run 7
        issue_request(REQ_POP,    3'd2, '0);          // run 7 now open and empty
        wait_merge_quiet();
        issue_request(REQ_FINISH, 3'd7, '0);
        issue_request(REQ_FINISH, 3'd7, '0);          // second finish is harmless
        issue_request(REQ_PUSH,   3'd7, 32'sd5);      // finished run refuses data
        issue_request(REQ_UNDEF,  3'd7, VAL_MIN);
        issue_request(REQ_POP,    3'd0, '0);
        issue_request(REQ_POP,    3'd0, '0);          // run 3 open and empty
        issue_request(REQ_FINISH, 3'd3, '0);
        issue_request(REQ_FINISH, 3'd0, '0);
        issue_request(REQ_FINISH, 3'd5, '0);
        issue_request(REQ_POP,    3'd0, '0);          // tie: lower run wins
        issue_request(REQ_POP,    3'd0, '0);          // last value of the merge
        issue_request(REQ_POP,    3'd0, '0);          // nothing live
        issue_request(REQ_PUSH,   3'd6, '0);
    endtask

    // Register extremes, clamping, out-of-range runs and clearing on write.
    task automatic test_run_count_register();
        src_gaps    = 1'b1;
        sink_stalls = 1'b0;
        write_run_count(4'd0);                        // acts as one run
        issue_request(REQ_PUSH,   3'd1, 32'sd9);
        issue_request(REQ_FINISH, 3'd7, '0);
        issue_request(REQ_PUSH,   3'd0, 32'sd42);
        issue_request(REQ_POP,    3'd0, '0);
        issue_request(REQ_FINISH, 3'd0, '0);
        issue_request(REQ_POP,    3'd0, '0);
        issue_request(REQ_PUSH,   3'd0, 32'sd7);
        write_run_count(4'd15);                       // clamps to all runs, clears run 0
        issue_request(REQ_POP,    3'd0, '0);
        issue_request(REQ_PUSH,   3'd7, -32'sd3);
        write_run_count(4'd9);
        for (int r = 0; r < MAX_RUNS; r++) begin
            issue_request(REQ_FINISH, RUN_W'(r), '0);
        end
        issue_request(REQ_POP,    3'd0, '0);
        write_run_count(4'd2);
        issue_request(REQ_PUSH,   3'd2, 32'sd1);
        issue_request(REQ_PUSH,   3'd1, 32'sd1);
        issue_request(REQ_FINISH, 3'd0, '0);
        issue_request(REQ_POP,    3'd0, '0);
        issue_request(REQ_FINISH, 3'd1, '0);
        issue_request(REQ_POP,    3'd0, '0);
    endtask

    // One run filled to the brim, refusal when full, then pointer wrap.
    task automatic test_full_buffer();
        src_gaps    = 1'b0;
        sink_stalls = 1'b1;
        write_run_count(4'd1);
        for (int i = 0; i < BUFFER_DEPTH; i++) begin
            issue_request(REQ_PUSH, 3'd0, DATA_W'(i * 3 - 100));
        end
        issue_request(REQ_PUSH, 3'd0, VAL_MAX);       // full
        for (int i = 0; i < 10; i++) issue_request(REQ_POP, 3'd0, '0);
        for (int i = 0; i < 10; i++) begin
            issue_request(REQ_PUSH, 3'd0, DATA_W'(1000 + i));
        end
        issue_request(REQ_PUSH, 3'd0, VAL_MIN);       // full again
        issue_request(REQ_FINISH, 3'd0, '0);
        for (int i = 0; i <= BUFFER_DEPTH; i++) issue_request(REQ_POP, 3'd0, '0);
    endtask

    // Random merge sessions: sorted runs of random length pushed in random
    // order, interleaved with pops and finishes, plus a little junk traffic.
    task automatic test_random_merges(input int unsigned target);
        int unsigned counted;
        int unsigned k;
        int unsigned steps;
        int unsigned roll;
        int unsigned pick;
        int unsigned plan  [MAX_RUNS];
        int unsigned pushed[MAX_RUNS];
        longint      cursor[MAX_RUNS];
        longint      span;
        bit          starving;
        bit          open_found;
        bit          merge_over;
        logic [CFG_W-1:0] code;
        counted = 0;
        while (counted < target) begin
            k = $urandom_range(1, MAX_RUNS);
            code = CFG_W'(k);
            if (k == 1 && $urandom_range(0, 1) == 1) code = '0;
            if (k == MAX_RUNS && $urandom_range(0, 1) == 1) begin
                code = CFG_W'($urandom_range(9, 15));
            end
            write_run_count(code);
            n_sessions++;
            case ($urandom_range(0, 3))
                0: begin src_gaps = 1'b1; sink_stalls = 1'b1; end
                1: begin src_gaps = 1'b0; sink_stalls = 1'b0; end
                2: begin src_gaps = 1'b1; sink_stalls = 1'b0; end
                default: begin src_gaps = 1'b0; sink_stalls = 1'b1; end
            endcase
            case ($urandom_range(0, 2))
                0: span = 2;                          // many ties
                1: span = 1000;
                default: span = longint'(1) << 30;
            endcase
            for (int r = 0; r < MAX_RUNS; r++) begin
                plan[r]   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                pushed[r] = 0;
                case ($urandom_range(0, 2))
                    0: cursor[r] = longint'(VAL_MIN);
                    1: cursor[r] = longint'($signed($urandom));
                    default: cursor[r] = longint'($urandom_range(0, 10)) - 5;
                endcase
            end
            merge_over = 1'b0;
            steps      = 0;
            while (!merge_over && steps < 400) begin
                roll     = $urandom_range(0, 99);
                starving = 1'b0;
                for (int r = 0; r < MAX_RUNS; r++) begin
                    if (r < run_count && !run_closed[r] && run_fill[r] == 0) starving = 1'b1;
                end
                if (roll < 8) begin
                    // junk: any code, any run, any value (unsorted pushes included)
                    issue_request(REQ_W'($urandom_range(0, 3)), RUN_W'($urandom_range(0, 7)),
                                  DATA_W'($urandom));
                end else if (!starving && roll < 55) begin
                    issue_request(REQ_POP, RUN_W'($urandom_range(0, 7)), DATA_W'($urandom));
                end else begin
                    pick       = $urandom_range(0, run_count - 1);
                    open_found = 1'b0;
                    for (int i = 0; i < MAX_RUNS; i++) begin
                        if (!open_found && i < run_count) begin
                            if (!run_closed[(pick + i) % run_count]) begin
                                pick       = (pick + i) % run_count;
                                open_found = 1'b1;
                            end
                        end
                    end
                    if (!open_found) begin
                        issue_request(REQ_POP, '0, '0);
                    end else if (pushed[pick] < plan[pick] &&
                                 run_fill[pick] < BUFFER_DEPTH) begin
                        cursor[pick] = cursor[pick] + longint'($urandom_range(0, span));
                        if (cursor[pick] > longint'(VAL_MAX)) cursor[pick] = longint'(VAL_MAX);
                        issue_request(REQ_PUSH, RUN_W'(pick), DATA_W'(cursor[pick]));
                        pushed[pick]++;
                    end else begin
                        issue_request(REQ_FINISH, RUN_W'(pick), DATA_W'($urandom));
                    end
                end
                if (latest_outcome.status != ST_REJECT) counted++;
                if (latest_outcome.status == ST_DONE)   merge_over = 1'b1;
                // now and then let the pipeline run completely dry
                if ($urandom_range(0, 99) == 0) wait_merge_quiet();
                steps++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin : sequencer
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        err_count   = 0;
        run_count   = ACT_W'(MAX_RUNS);
        clear_runs();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_merge_rules();
        test_run_count_register();
        test_full_buffer();
        test_random_merges(480);

        wait_merge_quiet();
        repeat (10) @(posedge aclk);

        $display("Covered %0d request transactions in %0d random merges, %0d run count writes.",
                 n_requests, n_sessions, n_cfg_writes);
        $display("Seen: %0d pops (%0d ending a merge), %0d stalls, %0d rejects, %0d all-done.",
                 n_pops, n_closing, n_stalls, n_rejects, n_done);
        if (err_count == 0 && pending_outcomes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== k_way_merge_selector_unit.f =====
design/kwms_pkg.sv
design/kwms_datapath.sv
design/kwms_ctrl.sv
design/k_way_merge_selector_unit.sv
design/kwms_checker.sv
dv/tb_k_way_merge_selector_unit.sv
